// ----- design/subtractive_lagged_random_generator_core_macros.svh -----
// Assertion macros for the subtractive lagged generator core.
`ifndef SUBTRACTIVE_LAGGED_RANDOM_GENERATOR_CORE_MACROS_SVH
`define SUBTRACTIVE_LAGGED_RANDOM_GENERATOR_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SLRG_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slrg assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SLRG_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slrg assertion failed");

`endif

// ----- design/slrg_pkg.sv -----
// Shared types, constants and microcode encodings for the subtractive lagged generator.
`default_nettype none
package slrg_pkg;

	localparam int TABLE_LEN  = 55;
	localparam int LAG_GAP    = 31;
	localparam int FILL_STEP  = 21;
	localparam int FILL_CNT   = 54;
	localparam int MIX_PASSES = 4;

	localparam int WORD_W = 30;
	localparam int SLOT_W = 6;
	localparam int STEP_W = 4;
	localparam int CNT_W  = 8;
	localparam int SEED_W = 29;
	localparam int FRAC_W = 32;
	localparam int PROD_W = 62;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [STEP_W-1:0] step_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam word_t MOD_BIG = 30'd1000000000;
	localparam logic [SEED_W-1:0] SEED_BASE = 29'd161803398;

	// fraction = 4*d + floor(d * 0.294967296); K approximates 0.294967296 in Q0.32
	localparam logic [63:0] FRAC_K64 = (64'd294967296 << 32) / 64'd1000000000;
	localparam logic [FRAC_W-1:0] FRAC_K = FRAC_K64[FRAC_W-1:0];
	localparam logic [FRAC_W-1:0] FRAC_C = 32'd294967296;

	localparam slot_t SLOT_LAST  = SLOT_W'(TABLE_LEN - 1);
	localparam slot_t SLOT_LAG   = SLOT_W'(LAG_GAP);
	localparam slot_t FILL_START = SLOT_W'(FILL_STEP - 1);
	localparam cnt_t  FILL_LAST  = CNT_W'(FILL_CNT - 1);
	localparam cnt_t  MIX_LAST   = CNT_W'(MIX_PASSES * TABLE_LEN - 1);

	localparam step_t S_IDLE      = 4'd0;
	localparam step_t S_DISPATCH  = 4'd1;
	localparam step_t S_FILL_INIT = 4'd2;
	localparam step_t S_FILL      = 4'd3;
	localparam step_t S_MIX_PRIME = 4'd4;
	localparam step_t S_MIX       = 4'd5;
	localparam step_t S_DRAW_RD   = 4'd6;
	localparam step_t S_DRAW_WR   = 4'd7;
	localparam step_t S_FR1       = 4'd8;
	localparam step_t S_FR2       = 4'd9;
	localparam step_t S_FR3       = 4'd10;
	localparam step_t S_FR4       = 4'd11;

	typedef enum logic [2:0] {
		C_NEXT,
		C_NO_IN,
		C_NO_RESEED,
		C_FILL_MORE,
		C_MIX_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_DK,
		MUL_DC,
		MUL_QM
	} mul_sel_t;

	typedef struct packed {
		cond_t    cond;
		step_t    br_step;
		step_t    seq_step;
		logic     take_in;
		logic     fill_init;
		logic     fill_step;
		logic     mix_prime;
		logic     mix_step;
		logic     draw_rd;
		logic     draw_wr;
		mul_sel_t mul_sel;
		logic     emit;
	} uword_t;

	typedef struct packed {
		logic no_reseed;
		logic fill_more;
		logic mix_more;
	} dp_flags_t;

	typedef struct packed {
		logic      no_in;
		logic      out_busy;
		dp_flags_t dp;
	} status_t;

	typedef struct packed {
		word_t             deviate;
		logic [FRAC_W-1:0] fraction;
		logic              reseeded;
	} result_t;

endpackage
`default_nettype wire

// ----- design/slrg_sequencer.sv -----
// Microcode ROM, step counter and branch logic.
`default_nettype none
module slrg_sequencer (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire slrg_pkg::status_t st,
	output slrg_pkg::uword_t      uw
);

	function automatic slrg_pkg::uword_t ucode(input slrg_pkg::step_t s);
		slrg_pkg::uword_t w;
		w = '0;
		w.cond     = slrg_pkg::C_NEXT;
		w.mul_sel  = slrg_pkg::MUL_NONE;
		w.br_step  = slrg_pkg::S_IDLE;
		w.seq_step = slrg_pkg::S_IDLE;
		case (s)
			slrg_pkg::S_IDLE: begin
				w.take_in  = 1'b1;
				w.cond     = slrg_pkg::C_NO_IN;
				w.br_step  = slrg_pkg::S_IDLE;
				w.seq_step = slrg_pkg::S_DISPATCH;
			end
			slrg_pkg::S_DISPATCH: begin
				w.cond     = slrg_pkg::C_NO_RESEED;
				w.br_step  = slrg_pkg::S_DRAW_RD;
				w.seq_step = slrg_pkg::S_FILL_INIT;
			end
			slrg_pkg::S_FILL_INIT: begin
				w.fill_init = 1'b1;
				w.seq_step  = slrg_pkg::S_FILL;
			end
			slrg_pkg::S_FILL: begin
				w.fill_step = 1'b1;
				w.cond      = slrg_pkg::C_FILL_MORE;
				w.br_step   = slrg_pkg::S_FILL;
				w.seq_step  = slrg_pkg::S_MIX_PRIME;
			end
			slrg_pkg::S_MIX_PRIME: begin
				w.mix_prime = 1'b1;
				w.seq_step  = slrg_pkg::S_MIX;
			end
			slrg_pkg::S_MIX: begin
				w.mix_step = 1'b1;
				w.cond     = slrg_pkg::C_MIX_MORE;
				w.br_step  = slrg_pkg::S_MIX;
				w.seq_step = slrg_pkg::S_DRAW_RD;
			end
			slrg_pkg::S_DRAW_RD: begin
				w.draw_rd  = 1'b1;
				w.seq_step = slrg_pkg::S_DRAW_WR;
			end
			slrg_pkg::S_DRAW_WR: begin
				w.draw_wr  = 1'b1;
				w.seq_step = slrg_pkg::S_FR1;
			end
			slrg_pkg::S_FR1: begin
				w.mul_sel  = slrg_pkg::MUL_DK;
				w.seq_step = slrg_pkg::S_FR2;
			end
			slrg_pkg::S_FR2: begin
				w.mul_sel  = slrg_pkg::MUL_DC;
				w.seq_step = slrg_pkg::S_FR3;
			end
			slrg_pkg::S_FR3: begin
				w.mul_sel  = slrg_pkg::MUL_QM;
				w.seq_step = slrg_pkg::S_FR4;
			end
			slrg_pkg::S_FR4: begin
				w.emit     = 1'b1;
				w.cond     = slrg_pkg::C_OUT_BUSY;
				w.br_step  = slrg_pkg::S_FR4;
				w.seq_step = slrg_pkg::S_IDLE;
			end
			default: begin
				w.seq_step = slrg_pkg::S_IDLE;
			end
		endcase
		return w;
	endfunction

	slrg_pkg::step_t upc_q;
	slrg_pkg::step_t upc_d;
	logic            hit;

	assign uw = ucode(upc_q);

	always_comb begin
		case (uw.cond)
			slrg_pkg::C_NEXT:      hit = 1'b0;
			slrg_pkg::C_NO_IN:     hit = st.no_in;
			slrg_pkg::C_NO_RESEED: hit = st.dp.no_reseed;
			slrg_pkg::C_FILL_MORE: hit = st.dp.fill_more;
			slrg_pkg::C_MIX_MORE:  hit = st.dp.mix_more;
			slrg_pkg::C_OUT_BUSY:  hit = st.out_busy;
			default:               hit = 1'b0;
		endcase
		upc_d = hit ? uw.br_step : uw.seq_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= slrg_pkg::S_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule
`default_nettype wire

// ----- design/slrg_datapath.sv -----
// Lag table memory, fill and mix registers, pointers and the shared fraction multiplier.
`default_nettype none
module slrg_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire slrg_pkg::uword_t                    uw,
	input  wire logic                                in_valid,
	input  wire logic signed [slrg_pkg::SEED_W-1:0]  seed,
	output slrg_pkg::dp_flags_t                      flags,
	output slrg_pkg::result_t                        res
);

	function automatic slrg_pkg::word_t modsub(input slrg_pkg::word_t a, input slrg_pkg::word_t b);
		logic [slrg_pkg::WORD_W:0] diff;
		diff = {1'b0, a} - {1'b0, b};
		if (a < b)
			diff = diff + {1'b0, slrg_pkg::MOD_BIG};
		return diff[slrg_pkg::WORD_W-1:0];
	endfunction

	function automatic slrg_pkg::slot_t next_slot(input slrg_pkg::slot_t s);
		return (s == slrg_pkg::SLOT_LAST) ? '0 : s + 1'b1;
	endfunction

	slrg_pkg::word_t mem [slrg_pkg::TABLE_LEN];

	logic                           seeded_q;
	logic                           reseed_q;
	slrg_pkg::slot_t                lead_q;
	slrg_pkg::slot_t                trail_q;
	slrg_pkg::cnt_t                 cnt_q;

	logic [slrg_pkg::SEED_W-1:0]    seed_q;
	slrg_pkg::word_t                cur_q;
	slrg_pkg::word_t                nxt_q;
	slrg_pkg::slot_t                fs_q;
	slrg_pkg::slot_t                mi_q;
	slrg_pkg::slot_t                mj_q;
	slrg_pkg::slot_t                mw_q;
	slrg_pkg::word_t                rda_q;
	slrg_pkg::word_t                rdb_q;
	slrg_pkg::word_t                d_q;
	slrg_pkg::word_t                q_q;
	logic [slrg_pkg::PROD_W-1:0]    prod_q;
	logic [slrg_pkg::PROD_W-1:0]    n_q;

	logic                           take;
	logic [slrg_pkg::SEED_W-1:0]    mag;
	logic [slrg_pkg::SEED_W-1:0]    mag_sat;
	slrg_pkg::word_t                cur_init;
	logic [slrg_pkg::SLOT_W:0]      fs_sum;
	slrg_pkg::slot_t                fs_next;
	slrg_pkg::word_t                diff;
	slrg_pkg::slot_t                rd_a;
	slrg_pkg::slot_t                rd_b;
	logic                           mem_we;
	slrg_pkg::slot_t                mem_wa;
	slrg_pkg::word_t                mem_wd;
	slrg_pkg::word_t                mul_a;
	logic [slrg_pkg::FRAC_W-1:0]    mul_b;
	logic [slrg_pkg::PROD_W-1:0]    prod_d;
	logic [slrg_pkg::PROD_W-1:0]    rem;
	logic                           rnd;

	assign take = uw.take_in && in_valid;

	always_comb begin
		mag      = seed_q[slrg_pkg::SEED_W-1] ? (~seed_q + 1'b1) : seed_q;
		mag_sat  = (mag > slrg_pkg::SEED_BASE) ? slrg_pkg::SEED_BASE : mag;
		cur_init = slrg_pkg::WORD_W'(slrg_pkg::SEED_BASE - mag_sat);

		fs_sum  = {1'b0, fs_q} + (slrg_pkg::SLOT_W+1)'(slrg_pkg::FILL_STEP);
		fs_next = (fs_sum >= (slrg_pkg::SLOT_W+1)'(slrg_pkg::TABLE_LEN))
			? slrg_pkg::SLOT_W'(fs_sum - (slrg_pkg::SLOT_W+1)'(slrg_pkg::TABLE_LEN))
			: slrg_pkg::SLOT_W'(fs_sum);

		diff = modsub(rda_q, rdb_q);

		rd_a = uw.draw_rd ? lead_q : mi_q;
		rd_b = uw.draw_rd ? trail_q : mj_q;

		mem_we = 1'b0;
		mem_wa = mw_q;
		mem_wd = diff;
		if (uw.fill_init) begin
			mem_we = 1'b1;
			mem_wa = slrg_pkg::SLOT_LAST;
			mem_wd = cur_init;
		end else if (uw.fill_step) begin
			mem_we = 1'b1;
			mem_wa = fs_q;
			mem_wd = nxt_q;
		end else if (uw.mix_step) begin
			mem_we = 1'b1;
		end else if (uw.draw_wr) begin
			mem_we = 1'b1;
			mem_wa = lead_q;
		end

		case (uw.mul_sel)
			slrg_pkg::MUL_DK: begin
				mul_a = d_q;
				mul_b = slrg_pkg::FRAC_K;
			end
			slrg_pkg::MUL_DC: begin
				mul_a = d_q;
				mul_b = slrg_pkg::FRAC_C;
			end
			slrg_pkg::MUL_QM: begin
				mul_a = q_q;
				mul_b = slrg_pkg::FRAC_W'(slrg_pkg::MOD_BIG);
			end
			default: begin
				mul_a = d_q;
				mul_b = '0;
			end
		endcase
		prod_d = slrg_pkg::PROD_W'(mul_a) * slrg_pkg::PROD_W'(mul_b);

		// estimate is at most one low; remainder decides the correction
		rem = n_q - prod_q;
		rnd = rem >= slrg_pkg::PROD_W'(slrg_pkg::MOD_BIG);
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rda_q <= mem[rd_a];
		rdb_q <= mem[rd_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
			reseed_q <= 1'b0;
			lead_q   <= '0;
			trail_q  <= slrg_pkg::SLOT_LAG;
			cnt_q    <= '0;
		end else begin
			if (take)
				reseed_q <= seed[slrg_pkg::SEED_W-1] || !seeded_q;
			if (uw.fill_init) begin
				seeded_q <= 1'b1;
				lead_q   <= '0;
				trail_q  <= slrg_pkg::SLOT_LAG;
				cnt_q    <= '0;
			end
			if (uw.fill_step || uw.mix_step)
				cnt_q <= cnt_q + 1'b1;
			if (uw.mix_prime)
				cnt_q <= '0;
			if (uw.draw_wr) begin
				lead_q  <= next_slot(lead_q);
				trail_q <= next_slot(trail_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			seed_q <= seed;
		if (uw.fill_init) begin
			cur_q <= cur_init;
			nxt_q <= slrg_pkg::WORD_W'(1);
			fs_q  <= slrg_pkg::FILL_START;
			mi_q  <= '0;
			mj_q  <= slrg_pkg::SLOT_LAG;
		end
		if (uw.fill_step) begin
			nxt_q <= modsub(cur_q, nxt_q);
			cur_q <= nxt_q;
			fs_q  <= fs_next;
		end
		if (uw.mix_prime || uw.mix_step) begin
			mi_q <= next_slot(mi_q);
			mj_q <= next_slot(mj_q);
			mw_q <= mi_q;
		end
		if (uw.draw_wr)
			d_q <= diff;
		case (uw.mul_sel)
			slrg_pkg::MUL_DK: begin
				prod_q <= prod_d;
			end
			slrg_pkg::MUL_DC: begin
				q_q    <= prod_q[slrg_pkg::PROD_W-1:slrg_pkg::FRAC_W];
				prod_q <= prod_d;
			end
			slrg_pkg::MUL_QM: begin
				n_q    <= prod_q;
				prod_q <= prod_d;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		flags.no_reseed = !reseed_q;
		flags.fill_more = cnt_q != slrg_pkg::FILL_LAST;
		flags.mix_more  = cnt_q != slrg_pkg::MIX_LAST;
		res.deviate     = d_q;
		res.fraction    = {d_q, 2'b00} + slrg_pkg::FRAC_W'(q_q) + slrg_pkg::FRAC_W'(rnd);
		res.reseeded    = reseed_q;
	end

endmodule
`default_nettype wire

// ----- design/subtractive_lagged_random_generator_core.sv -----
// Top level of the subtractive lagged generator: sequencer, datapath and result register.
// A plain draw goes from the accepted beat through dispatch, table read and write, three multiply
// steps and the emit step, eight microcode steps in all with idle; the next beat is taken after emit.
// A reseed (first beat after reset or negative seed) first runs 55 fill writes and 4 mix passes.
// Reset is asynchronous, active low: table marked unseeded, pointers home, no result held.
`default_nettype none
`include "subtractive_lagged_random_generator_core_macros.svh"
module subtractive_lagged_random_generator_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [slrg_pkg::SEED_W-1:0]  seed,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [slrg_pkg::WORD_W-1:0]              deviate,
	output logic [slrg_pkg::FRAC_W-1:0]              fraction,
	output logic                                     reseeded
);

	slrg_pkg::uword_t    uw;
	slrg_pkg::status_t   st;
	slrg_pkg::dp_flags_t dp_flags;
	slrg_pkg::result_t   res;

	logic                out_valid_q;
	slrg_pkg::result_t   res_q;
	logic                out_free;

	assign out_free    = !out_valid_q || out_ready;
	assign st.no_in    = !in_valid;
	assign st.out_busy = !out_free;
	assign st.dp       = dp_flags;
	assign in_ready    = uw.take_in;

	slrg_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.uw     (uw)
	);

	slrg_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.uw       (uw),
		.in_valid (in_valid),
		.seed     (seed),
		.flags    (dp_flags),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uw.emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.emit && out_free)
			res_q <= res;
	end

	assign out_valid = out_valid_q;
	assign deviate   = res_q.deviate;
	assign fraction  = res_q.fraction;
	assign reseeded  = res_q.reseeded;

	`SLRG_ASSERT_IMP(a_dev_range, out_valid, deviate < slrg_pkg::MOD_BIG)
	`SLRG_ASSERT_IMP(a_frac_floor, out_valid, fraction[slrg_pkg::FRAC_W-1:2] >= deviate)
	`SLRG_ASSERT_NXT(a_neg_reseed, in_valid && in_ready && seed[slrg_pkg::SEED_W-1], !dp_flags.no_reseed)

endmodule
`default_nettype wire
